// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, reset-gated on rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define KWM_ASSERT_NEVER(lbl, cond, msg) `KWM_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// types, command codes and key helpers shared by the record merge blocks
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned KeyBytes = 8;
  localparam int unsigned KeyW     = 8 * KeyBytes;
  localparam int unsigned LenW     = 4;
  localparam int unsigned SrcW     = 4;
  localparam int unsigned RefW     = 32;
  localparam int unsigned CfgW     = 5;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(16);

  typedef enum logic {
    CmdRecord  = 1'b0,
    CmdExhaust = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [SrcW-1:0]   source;
    logic [KeyW-1:0]   key;
    logic [LenW-1:0]   key_length;
    logic [RefW-1:0]   value_ref;
  } in_item_t;

  typedef struct packed {
    logic [SrcW-1:0]   out_source;
    logic [KeyW-1:0]   out_key;
    logic [LenW-1:0]   out_key_length;
    logic [RefW-1:0]   out_value_ref;
    logic              done_res;
  } out_item_t;

  // one stored head record; field order gives the merge order
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [LenW-1:0]   key_length;
    logic [SrcW-1:0]   source;
    logic [RefW-1:0]   value_ref;
  } head_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic  valid;
    logic  lt;
    head_t head;
  } link_t;

  typedef struct packed {
    logic ins;
    logic del;
  } chain_ctrl_t;

  function automatic logic [LenW-1:0] len_sat(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    res = (len > LenW'(KeyBytes)) ? LenW'(KeyBytes) : len;
    return res;
  endfunction

  // keep only the first len bytes, first byte at the top
  function automatic logic [KeyW-1:0] key_mask(input logic [LenW-1:0] len);
    logic [KeyW-1:0] m;
    m = '0;
    for (int b = 0; b < KeyBytes; b++) begin
      if (LenW'(b) < len) begin
        m[KeyW-1-8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/kwm_cell.sv -----
// ----------------------------------------------------------------------------
// kwm_cell
// one slot of the sorted head chain: holds a head, compares it with the
// broadcast record and shifts toward either neighbor
// ----------------------------------------------------------------------------
module kwm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kwm_pkg::chain_ctrl_t ctrl_i,
  input  kwm_pkg::head_t      new_i,
  input  kwm_pkg::link_t      prev_i,
  input  kwm_pkg::link_t      next_i,
  input  logic                shift_i,
  output kwm_pkg::link_t      link_o
);

  logic           valid_q, valid_d;
  kwm_pkg::head_t head_q, head_d;
  logic           lt;

  // order is key, then length, then source index
  always_comb begin
    lt = !valid_q ||
         ({new_i.key, new_i.key_length, new_i.source} <
          {head_q.key, head_q.key_length, head_q.source});
    link_o.valid = valid_q;
    link_o.lt    = lt;
    link_o.head  = head_q;
  end

  always_comb begin
    valid_d = valid_q;
    head_d  = head_q;
    if (ctrl_i.ins) begin
      if (prev_i.lt) begin
        valid_d = prev_i.valid;
        head_d  = prev_i.head;
      end else if (lt) begin
        valid_d = 1'b1;
        head_d  = new_i;
      end
    end else if (ctrl_i.del && shift_i) begin
      valid_d = next_i.valid;
      head_d  = next_i.head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

endmodule

// ----- hw/rtl/kwm_head_chain.sv -----
// ----------------------------------------------------------------------------
// kwm_head_chain
// row of cells keeping the valid heads sorted; inserts one record or
// removes the smallest eligible head per cycle
// ----------------------------------------------------------------------------
module kwm_head_chain #(
  parameter int unsigned MAX_SOURCES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kwm_pkg::chain_ctrl_t   ctrl_i,
  input  kwm_pkg::head_t         new_i,
  input  logic [7:0]             n_i,
  output kwm_pkg::head_t         pop_head_o,
  output logic [MAX_SOURCES-1:0] valid_o
);

  kwm_pkg::link_t         links [MAX_SOURCES];
  kwm_pkg::link_t         prevs [MAX_SOURCES];
  kwm_pkg::link_t         nexts [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] elig;
  logic [MAX_SOURCES-1:0] first;
  logic [MAX_SOURCES-1:0] shift;

  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      prevs[i] = (i == 0) ? kwm_pkg::link_t'('0) : links[(i == 0) ? 0 : i-1];
      nexts[i] = (i == MAX_SOURCES-1) ? kwm_pkg::link_t'('0)
                                      : links[(i == MAX_SOURCES-1) ? i : i+1];
      elig[i]    = links[i].valid && (8'(links[i].head.source) < n_i);
      valid_o[i] = links[i].valid;
    end
  end

  // heads of sources outside the active range are skipped, not popped
  assign first = elig & (~elig + MAX_SOURCES'(1));
  assign shift = ~(first - MAX_SOURCES'(1));

  always_comb begin
    pop_head_o = '0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (first[i]) begin
        pop_head_o = pop_head_o | links[i].head;
      end
    end
  end

  for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_cell
    kwm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .new_i   (new_i),
      .prev_i  (prevs[g]),
      .next_i  (nexts[g]),
      .shift_i (shift[g]),
      .link_o  (links[g])
    );
  end

endmodule

// ----- hw/rtl/k_way_record_merge.sv -----
// result path: an accepted transaction first sets eval_q; the decision it owes then fires into out_q
// throughput: one transaction per cycle while some active source still waits;
//   after the transaction that fills the last head, input is held until the pop fires (insert, then pop)
// the sorted cell chain inserts or pops once per cycle, which sets that figure
// reset: all sources waiting, chain empty, active_sources 16, output empty
// ----------------------------------------------------------------------------
// k_way_record_merge
// merges key-sorted record streams through a sorted chain of head cells
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module k_way_record_merge #(
  parameter int unsigned MAX_SOURCES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kwm_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kwm_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kwm_pkg::out_item_t        out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_SOURCES);
  localparam logic [7:0]  MaxN = 8'(MAX_SOURCES);

  logic [kwm_pkg::CfgW-1:0] active_q;
  logic [MAX_SOURCES-1:0]   pending_q, pending_d;
  logic [MAX_SOURCES-1:0]   exhausted_q, exhausted_d;
  logic                     finished_q, finished_d;
  logic                     eval_q, eval_d;
  logic                     out_valid_q, out_valid_d;
  kwm_pkg::out_item_t       out_q, out_d;

  logic [7:0]               cfg8, n8;
  logic [MAX_SOURCES-1:0]   active_mask;
  logic                     any_pending, any_valid;
  logic                     due, fire, in_acc, upd;
  logic [kwm_pkg::LenW-1:0] len_in;
  logic [IdxW-1:0]          in_idx, pop_idx;
  kwm_pkg::head_t           new_head, pop_head;
  kwm_pkg::chain_ctrl_t     ctrl;
  logic [MAX_SOURCES-1:0]   cell_valid;

  assign cfg8 = 8'(active_q);
  assign n8   = (cfg8 == 8'd0) ? 8'd1 : ((cfg8 > MaxN) ? MaxN : cfg8);

  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      active_mask[i] = 8'(i) < n8;
    end
  end

  assign any_pending = |(pending_q & active_mask);
  assign any_valid   = |(~pending_q & ~exhausted_q & active_mask);

  // a decision is owed after every transaction, once no active source waits
  assign due    = eval_q && !finished_q && !any_pending;
  assign fire   = due && (!out_valid_q || out_ready_i);
  assign in_ready_o = !due;
  assign in_acc = in_valid_i && in_ready_o;

  assign in_idx = IdxW'(in_data_i.source);
  assign upd    = in_acc && !finished_q && (8'(in_data_i.source) < n8) &&
                  pending_q[in_idx];

  always_comb begin
    len_in              = kwm_pkg::len_sat(in_data_i.key_length);
    new_head.key        = in_data_i.key & kwm_pkg::key_mask(len_in);
    new_head.key_length = len_in;
    new_head.source     = in_data_i.source;
    new_head.value_ref  = in_data_i.value_ref;
  end

  assign ctrl.ins = upd && (in_data_i.command == kwm_pkg::CmdRecord);
  assign ctrl.del = fire && any_valid;

  kwm_head_chain #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .new_i      (new_head),
    .n_i        (n8),
    .pop_head_o (pop_head),
    .valid_o    (cell_valid)
  );

  assign pop_idx = IdxW'(pop_head.source);

  always_comb begin
    pending_d   = pending_q;
    exhausted_d = exhausted_q;
    finished_d  = finished_q;
    eval_d      = eval_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (eval_q && (!due || fire)) begin
      eval_d = 1'b0;
    end
    if (in_acc && !finished_q) begin
      eval_d = 1'b1;
    end

    if (upd) begin
      pending_d[in_idx] = 1'b0;
      if (in_data_i.command == kwm_pkg::CmdExhaust) begin
        exhausted_d[in_idx] = 1'b1;
      end
    end

    if (fire) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (any_valid) begin
        out_d.out_source     = pop_head.source;
        out_d.out_key        = pop_head.key;
        out_d.out_key_length = pop_head.key_length;
        out_d.out_value_ref  = pop_head.value_ref;
        pending_d[pop_idx]   = 1'b1;
      end else begin
        out_d.done_res = 1'b1;
        finished_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= kwm_pkg::CfgReset;
      pending_q   <= '1;
      exhausted_q <= '0;
      finished_q  <= 1'b0;
      eval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        active_q <= cfg_data_i;
      end
      pending_q   <= pending_d;
      exhausted_q <= exhausted_d;
      finished_q  <= finished_d;
      eval_q      <= eval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KWM_ASSERT(a_finished_sticky, finished_q |=> finished_q, "finished flag dropped")
  `KWM_ASSERT_NEVER(a_status_overlap, (pending_q & exhausted_q) != '0, "source both waiting and exhausted")
  `KWM_ASSERT(a_chain_matches_status, $countones(cell_valid) == $countones(~pending_q & ~exhausted_q), "chain head count differs from status")
  `KWM_ASSERT(a_done_after_finish, (out_valid_o && out_data_o.done_res) |-> finished_q, "done result without finished flag")

endmodule
